// ----- rtl/core/wdq_pkg.sv -----
// Shared types, constants and field positions of the weighted deque.
`default_nettype none

package wdq_pkg;

  localparam int DEPTH       = 256;
  localparam int VALUE_BITS  = 16;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int VTOT_W      = VALUE_BITS + CNT_W;
  localparam int PROD_W      = VALUE_BITS + CNT_W;
  localparam int WSUM_W      = 32;

  // stream field widths
  localparam int KIND_W      = 2;
  localparam int IN_VAL_W    = 16;
  localparam int POP_W       = 16;

  // decoupling queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // stream bus widths, whole bytes
  localparam int IN_TDATA_W  = ((IN_VAL_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_RAW_W   = POP_W + CNT_W + WSUM_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  // result field positions
  localparam int OUT_POP_LSB  = 0;
  localparam int OUT_CNT_LSB  = POP_W;
  localparam int OUT_WSUM_LSB = POP_W + CNT_W;
  localparam int OUT_EMPTY_BIT = 0;
  localparam int OUT_FULL_BIT  = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC
  } back_state_t;

  typedef struct packed {
    logic                  is_push;
    logic                  at_back;
    logic [VALUE_BITS-1:0] value;
  } wdq_op_t;

  typedef struct packed {
    logic              valid;
    wdq_op_t           op;
  } wdq_queue_out_t;

  typedef struct packed {
    logic [POP_W-1:0]  popped_value;
    logic              was_empty;
    logic              was_full;
    logic [CNT_W-1:0]  entry_count;
    logic [WSUM_W-1:0] weighted_sum;
  } wdq_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/wdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wdq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wdq_front.sv -----
// Front end: accept requests, decode the kind, hold them in a short queue.
`default_nettype none

module wdq_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [wdq_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic [wdq_pkg::IN_TUSER_W-1:0]     in_tuser,
  output wdq_pkg::wdq_queue_out_t                 q_out,
  input  wire logic                               q_pop
);
  import wdq_pkg::*;

  wdq_op_t           entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  wdq_op_t           dec_op;
  logic              push;
  logic              pop;

  // decode the request kind
  always_comb begin
    dec_op.value = in_tdata[VALUE_BITS-1:0];
    unique case (kind_t'(in_tuser[KIND_W-1:0]))
      KIND_PUSH_FRONT: begin dec_op.is_push = 1'b1; dec_op.at_back = 1'b0; end
      KIND_PUSH_BACK:  begin dec_op.is_push = 1'b1; dec_op.at_back = 1'b1; end
      KIND_POP_FRONT:  begin dec_op.is_push = 1'b0; dec_op.at_back = 1'b0; end
      KIND_POP_BACK:   begin dec_op.is_push = 1'b0; dec_op.at_back = 1'b1; end
      default:         begin dec_op.is_push = 1'b0; dec_op.at_back = 1'b0; end
    endcase
  end

  assign in_tready   = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push        = in_tvalid && in_tready;
  assign pop         = q_pop && (cnt_r != '0);
  assign q_out.valid = (cnt_r != '0);
  assign q_out.op    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec_op;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wdq_back.sv -----
// Back end: ring buffer control, sum updates and the result register.
`default_nettype none

module wdq_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire wdq_pkg::wdq_queue_out_t q_in,
  output logic                         q_pop,
  output logic                         res_valid,
  output wdq_pkg::wdq_result_t         res,
  input  wire logic                    res_ready
);
  import wdq_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [ADDR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [VTOT_W-1:0] vtot_r, vtot_nxt;
  logic [WSUM_W-1:0] wsum_r, wsum_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  wdq_op_t           op_r, op_nxt;
  logic [POP_W-1:0]  popped_r, popped_nxt;
  logic              empty_r, empty_nxt;
  logic              full_r, full_nxt;
  logic              valid_r, valid_nxt;

  logic              out_free;
  logic              start;
  logic              finish;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic [ADDR_W-1:0] slot_tail;
  logic [ADDR_W-1:0] slot_last;
  logic [ADDR_W-1:0] front_dec;
  logic [ADDR_W-1:0] front_inc;

  function automatic logic [ADDR_W-1:0] slot_wrap(input logic [CNT_W:0] s);
    logic [CNT_W:0] w;
    begin
      w = (s >= (CNT_W+1)'(DEPTH)) ? s - (CNT_W+1)'(DEPTH) : s;
      return w[ADDR_W-1:0];
    end
  endfunction

  assign out_free  = !valid_r || res_ready;
  assign start     = (state_r == ST_IDLE) && q_in.valid && out_free;
  assign slot_tail = slot_wrap((CNT_W+1)'(front_r) + (CNT_W+1)'(count_r));
  assign slot_last = slot_wrap((CNT_W+1)'(front_r) + (CNT_W+1)'(count_r) - 1'b1);
  assign front_dec = (front_r == '0) ? ADDR_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == ADDR_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;

  wdq_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_in.op.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (q_in.op.is_push) begin
            if (q_in.op.at_back && count_r != CNT_W'(DEPTH)) begin
              state_nxt = ST_ACC;
            end
          end else if (count_r != '0) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: state_nxt = op_r.at_back ? ST_ACC : ST_IDLE;
      ST_ACC:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    vtot_nxt   = vtot_r;
    wsum_nxt   = wsum_r;
    prod_nxt   = prod_r;
    op_nxt     = op_r;
    popped_nxt = popped_r;
    empty_nxt  = empty_r;
    full_nxt   = full_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = slot_tail;
    ram_raddr  = front_r;
    q_pop      = 1'b0;
    finish     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          q_pop      = 1'b1;
          op_nxt     = q_in.op;
          popped_nxt = '0;
          empty_nxt  = 1'b0;
          full_nxt   = 1'b0;
          if (q_in.op.is_push) begin
            if (count_r == CNT_W'(DEPTH)) begin
              // drop the push
              full_nxt = 1'b1;
              finish   = 1'b1;
            end else if (!q_in.op.at_back) begin
              // every entry moves one deeper, new one lands at depth 1
              ram_we    = 1'b1;
              ram_waddr = front_dec;
              front_nxt = front_dec;
              wsum_nxt  = wsum_r + WSUM_W'(vtot_r) + WSUM_W'(q_in.op.value);
              vtot_nxt  = vtot_r + VTOT_W'(q_in.op.value);
              count_nxt = count_r + 1'b1;
              finish    = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = slot_tail;
              prod_nxt  = PROD_W'(q_in.op.value) * PROD_W'(count_r + 1'b1);
            end
          end else if (count_r == '0) begin
            empty_nxt = 1'b1;
            finish    = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = q_in.op.at_back ? slot_last : front_r;
          end
        end
      end
      ST_READ: begin
        popped_nxt = POP_W'(ram_rdata);
        if (op_r.at_back) begin
          prod_nxt = PROD_W'(ram_rdata) * PROD_W'(count_r);
        end else begin
          // remaining entries move one shallower
          wsum_nxt  = wsum_r - WSUM_W'(vtot_r);
          vtot_nxt  = vtot_r - VTOT_W'(ram_rdata);
          front_nxt = front_inc;
          count_nxt = count_r - 1'b1;
          finish    = 1'b1;
        end
      end
      ST_ACC: begin
        if (op_r.is_push) begin
          wsum_nxt  = wsum_r + WSUM_W'(prod_r);
          vtot_nxt  = vtot_r + VTOT_W'(op_r.value);
          count_nxt = count_r + 1'b1;
        end else begin
          wsum_nxt  = wsum_r - WSUM_W'(prod_r);
          vtot_nxt  = vtot_r - VTOT_W'(popped_r);
          count_nxt = count_r - 1'b1;
        end
        finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign valid_nxt = finish ? 1'b1 : (res_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      front_r <= '0;
      count_r <= '0;
      vtot_r  <= '0;
      wsum_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      vtot_r  <= vtot_nxt;
      wsum_r  <= wsum_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r   <= prod_nxt;
    op_r     <= op_nxt;
    popped_r <= popped_nxt;
    empty_r  <= empty_nxt;
    full_r   <= full_nxt;
  end

  // count and sum only change once the held result has been taken
  assign res_valid          = valid_r;
  assign res.popped_value   = popped_r;
  assign res.was_empty      = empty_r;
  assign res.was_full       = full_r;
  assign res.entry_count    = count_r;
  assign res.weighted_sum   = wsum_r;

endmodule

`default_nettype wire

// ----- rtl/core/weighted_deque_core.sv -----
// Top level of the weighted deque: front end, queue, back end and stream ports.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | request   | in_tvalid/tready   | tuser: kind; tdata: item_value
//  out_    | result    | out_tvalid/tready  | tuser: was_empty, was_full;
//          |           |                    | tdata: popped_value, entry_count, weighted_sum
//
// Flow: a request is registered in the front queue, then the back end
// finishes push front, a dropped push and a pop of an empty deque in ST_IDLE,
// push back after ST_ACC, pop front after ST_READ and pop back after ST_READ
// and ST_ACC; the ring buffer read and the depth product are registered.
// Reset: rst_n clears pointers, count, sums and handshake state; the ring
// buffer itself is not cleared, no clearing pass is run.
// Stalls: the front queue keeps taking requests while a result waits on
// out_tready, until its QUEUE_DEPTH entries are full; the back end starts the
// next request only once the result register is free.
`default_nettype none

module weighted_deque_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [15:0] item_value
  input  wire logic [wdq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] kind
  input  wire logic [wdq_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] popped_value, [24:16] entry_count, [56:25] weighted_sum, rest zero
  output logic [wdq_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // [0] was_empty, [1] was_full
  output logic [wdq_pkg::OUT_TUSER_W-1:0]        out_tuser
);
  import wdq_pkg::*;

  wdq_queue_out_t q_link;
  logic           q_pop;
  wdq_result_t    res;

  // accept and decode requests
  wdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_out     (q_link),
    .q_pop     (q_pop)
  );

  // carry out requests against the ring buffer and hold the result
  wdq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_in      (q_link),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  // pack the result fields, lowest field first, zero pad to whole bytes
  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_POP_LSB  +: POP_W]  = res.popped_value;
    out_tdata[OUT_CNT_LSB  +: CNT_W]  = res.entry_count;
    out_tdata[OUT_WSUM_LSB +: WSUM_W] = res.weighted_sum;
    out_tuser = '0;
    out_tuser[OUT_EMPTY_BIT] = res.was_empty;
    out_tuser[OUT_FULL_BIT]  = res.was_full;
  end

endmodule

`default_nettype wire

// ----- rtl/core/wdq_checker.sv -----
// Port-level checks of the weighted deque and their binding to the top level.
`default_nettype none

module wdq_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [wdq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic [wdq_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import wdq_pkg::*;

  logic [CNT_W-1:0] res_cnt;
  logic [POP_W-1:0] res_pop;

  assign res_cnt = out_tdata[OUT_CNT_LSB +: CNT_W];
  assign res_pop = out_tdata[OUT_POP_LSB +: POP_W];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[OUT_EMPTY_BIT] && out_tuser[OUT_FULL_BIT]))
    else $error("empty and full flagged together");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> res_cnt <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_EMPTY_BIT] |-> res_cnt == '0 && res_pop == '0)
    else $error("empty pop with entries or data");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_FULL_BIT] |-> res_cnt == CNT_W'(DEPTH) && res_pop == '0)
    else $error("dropped push below capacity");

endmodule

bind weighted_deque_core wdq_checker u_wdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- verif/tb_weighted_deque_core.sv -----
// Self-checking testbench for the weighted deque core, with a mirror of the deque.
`timescale 1ns / 1ps

module tb_weighted_deque_core;
  import wdq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 37;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // mirror of the deque contents and running sums
  logic [VALUE_BITS-1:0]  mirror_slots [DEPTH];
  logic [ADDR_W-1:0]      mirror_head  = '0;
  logic [CNT_W-1:0]       mirror_count = '0;
  logic [VTOT_W-1:0]      mirror_value_sum = '0;
  logic [WSUM_W-1:0]      mirror_weighted  = '0;

  wdq_result_t            pending_results [$];
  int unsigned            mismatch_count = 0;
  int unsigned            cycle_count    = 0;
  bit                     no_idle_phase  = 1'b0;

  weighted_deque_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Advance the mirror by one accepted request and queue the result it yields.
  task automatic predict_deque_result(input kind_t kind, input logic [VALUE_BITS-1:0] value);
    wdq_result_t       res;
    logic [ADDR_W-1:0] slot;
    res = '0;
    if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
      if (mirror_count == CNT_W'(DEPTH)) begin
        res.was_full = 1'b1;
      end else if (kind == KIND_PUSH_FRONT) begin
        // existing entries sink one place; the new one sits at depth 1
        mirror_head = mirror_head - 1'b1;
        mirror_slots[mirror_head] = value;
        mirror_weighted  = mirror_weighted + WSUM_W'(mirror_value_sum) + WSUM_W'(value);
        mirror_value_sum = mirror_value_sum + VTOT_W'(value);
        mirror_count     = mirror_count + 1'b1;
      end else begin
        slot = mirror_head + ADDR_W'(mirror_count);
        mirror_slots[slot] = value;
        mirror_weighted  = mirror_weighted + WSUM_W'(value) * WSUM_W'(mirror_count + 1'b1);
        mirror_value_sum = mirror_value_sum + VTOT_W'(value);
        mirror_count     = mirror_count + 1'b1;
      end
    end else begin
      if (mirror_count == '0) begin
        res.was_empty = 1'b1;
      end else if (kind == KIND_POP_FRONT) begin
        // remaining entries rise one place
        res.popped_value = mirror_slots[mirror_head];
        mirror_weighted  = mirror_weighted - WSUM_W'(mirror_value_sum);
        mirror_value_sum = mirror_value_sum - VTOT_W'(res.popped_value);
        mirror_head      = mirror_head + 1'b1;
        mirror_count     = mirror_count - 1'b1;
      end else begin
        slot = mirror_head + ADDR_W'(mirror_count - 1'b1);
        res.popped_value = mirror_slots[slot];
        mirror_weighted  = mirror_weighted
                           - WSUM_W'(res.popped_value) * WSUM_W'(mirror_count);
        mirror_value_sum = mirror_value_sum - VTOT_W'(res.popped_value);
        mirror_count     = mirror_count - 1'b1;
      end
    end
    res.entry_count  = mirror_count;
    res.weighted_sum = mirror_weighted;
    pending_results.push_back(res);
  endtask

  // Hold a request on the input channel until it is taken, with random gaps first outside the no-idle stretch.
  task automatic send_request(input kind_t kind, input logic [VALUE_BITS-1:0] value);
    int idle_cycles;
    idle_cycles = 0;
    if (!no_idle_phase) begin
      while ($urandom_range(99) < IDLE_PCT) idle_cycles++;
    end
    if (idle_cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (idle_cycles) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_TDATA_W'(value);
    do @(posedge clk); while (!in_tready);
    predict_deque_result(kind, value);
  endtask

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
    mismatch_count++;
  endtask

  // Ready side: stall at random except during the no-idle stretch.
  always @(posedge clk) begin
    out_tready <= no_idle_phase ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    wdq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, out_tdata);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[OUT_POP_LSB +: POP_W] != want.popped_value)
          report_mismatch("popped_value", want.popped_value, out_tdata[OUT_POP_LSB +: POP_W]);
        if (out_tuser[OUT_EMPTY_BIT] != want.was_empty)
          report_mismatch("was_empty", want.was_empty, out_tuser[OUT_EMPTY_BIT]);
        if (out_tuser[OUT_FULL_BIT] != want.was_full)
          report_mismatch("was_full", want.was_full, out_tuser[OUT_FULL_BIT]);
        if (out_tdata[OUT_CNT_LSB +: CNT_W] != want.entry_count)
          report_mismatch("entry_count", want.entry_count, out_tdata[OUT_CNT_LSB +: CNT_W]);
        if (out_tdata[OUT_WSUM_LSB +: WSUM_W] != want.weighted_sum)
          report_mismatch("weighted_sum", want.weighted_sum,
                          out_tdata[OUT_WSUM_LSB +: WSUM_W]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly random values, with the extremes showing up often.
  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Push with the given percentage, else pop; the end is chosen at random.
  function automatic kind_t pick_kind(input int push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    return $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
  endfunction

  task automatic run_random(input int n_items, input int push_pct);
    kind_t k;
    repeat (n_items) begin
      k = pick_kind(push_pct);
      send_request(k, pick_value());
    end
  endtask

  // Pops on an empty deque must report empty and leave state alone.
  task automatic test_empty_pops();
    send_request(KIND_POP_FRONT, 16'hFFFF);
    send_request(KIND_POP_BACK, 16'h1234);
  endtask

  // Extremes at both ends, wrap of the head below slot zero, drain past empty.
  task automatic test_end_extremes();
    send_request(KIND_PUSH_FRONT, 16'hFFFF);
    send_request(KIND_PUSH_BACK,  16'h0000);
    send_request(KIND_PUSH_BACK,  16'hFFFF);
    send_request(KIND_PUSH_FRONT, 16'h0000);
    send_request(KIND_PUSH_FRONT, 16'h5555);
    send_request(KIND_PUSH_BACK,  16'hAAAA);
    send_request(KIND_PUSH_FRONT, 16'h0001);
    send_request(KIND_PUSH_BACK,  16'h8000);
    send_request(KIND_POP_BACK,   16'h0000);
    send_request(KIND_POP_FRONT,  16'hFFFF);
    send_request(KIND_POP_FRONT,  16'h0000);
    send_request(KIND_POP_BACK,   16'h0000);
    send_request(KIND_POP_BACK,   16'h0000);
    send_request(KIND_POP_FRONT,  16'h0000);
    send_request(KIND_POP_FRONT,  16'h0000);
    send_request(KIND_POP_BACK,   16'h0000);
    send_request(KIND_POP_FRONT,  16'h0000);
    send_request(KIND_POP_BACK,   16'h0000);
  endtask

  task automatic test_random_mix();
    run_random(200, 50);
  endtask

  // Back-to-back requests with the result side always ready.
  task automatic test_no_idle_stream();
    no_idle_phase = 1'b1;
    run_random(150, 55);
    no_idle_phase = 1'b0;
  endtask

  // Drive the deque to full and hold it there, then drain it to empty and past.
  task automatic test_fill_and_drain();
    run_random(400, 90);
    run_random(400, 10);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_pops();
    test_end_extremes();
    test_random_mix();
    test_no_idle_stream();
    test_fill_and_drain();
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
